### design/gwa_pkg.sv
// Package for the grouped weighted average block.
// Shared constants, state codes and the command/status types of the shared unit.
// No dependencies.
package gwa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_GROUP = 255;
    localparam int COUNT_W   = $clog2(MAX_GROUP + 1);

    // numerator of the reciprocal, 2^(2F)
    localparam logic [63:0] RECIP_NUM = 64'(1) << (2 * FRAC_BITS);

    typedef enum logic [0:0] {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic        start;
        unit_op_t    op;
        logic [63:0] a;
        logic [63:0] b;
    } unit_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } unit_sts_t;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_OPEN  = 10'b0000000010,
        S_RECIP = 10'b0000000100,
        S_MULW  = 10'b0000001000,
        S_ADDW  = 10'b0000010000,
        S_ADDSQ = 10'b0000100000,
        S_WDIV  = 10'b0001000000,
        S_SQRT  = 10'b0010000000,
        S_SQDIV = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } seq_state_t;

endpackage

### design/gwa_divsqrt.sv
// Shared iterative unit: 64/64 unsigned division, one quotient bit a cycle,
// and 64-bit integer square root, one root bit a cycle, on one subtractor.
// Depends on gwa_pkg.
module gwa_divsqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  gwa_pkg::unit_cmd_t cmd,
    output gwa_pkg::unit_sts_t sts
);

    gwa_pkg::unit_op_t op_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] rem_reg;
    logic [31:0] root_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] div_part;
    logic [34:0] sq_part;
    logic [33:0] sq_trial;
    logic [65:0] sub_x;
    logic [65:0] sub_y;
    logic [65:0] diff;
    logic        ge;

    // shared trial subtraction
    always_comb
    begin
        div_part = {rem_reg, a_reg[63]};
        sq_part  = {rem_reg[32:0], a_reg[63:62]};
        sq_trial = {root_reg, 2'b01};
        if (op_reg == gwa_pkg::OP_DIV)
        begin
            sub_x = {1'b0, div_part};
            sub_y = {2'b00, b_reg};
        end
        else
        begin
            sub_x = {31'd0, sq_part};
            sub_y = {32'd0, sq_trial};
        end
        diff = sub_x - sub_y;
        ge   = ~diff[65];
    end

    // iteration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= gwa_pkg::OP_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                a_reg    <= cmd.a;
                b_reg    <= cmd.b;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= (cmd.op == gwa_pkg::OP_DIV) ? 7'd64 : 7'd32;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (op_reg == gwa_pkg::OP_DIV)
                begin
                    rem_reg <= ge ? diff[63:0] : div_part[63:0];
                    a_reg   <= {a_reg[62:0], ge};
                end
                else
                begin
                    rem_reg  <= ge ? diff[63:0] : {29'd0, sq_part};
                    root_reg <= {root_reg[30:0], ge};
                    a_reg    <= {a_reg[61:0], 2'b00};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign sts.result = (op_reg == gwa_pkg::OP_DIV) ? a_reg : {32'd0, root_reg};

endmodule

### design/grouped_weighted_average.sv
// Grouped weighted average: takes points one at a time (s_tready drops while an
// item is worked on) and sums them per key. Each point costs two reciprocal
// divisions on the shared divide/root unit plus multiply and add steps. Closing a
// group of two or more costs two divisions, two roots and two scaling divisions
// on the same unit; a group of one skips the unit and hands its point out as is.
// Depends on gwa_pkg and gwa_divsqrt.
module grouped_weighted_average
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_key, mean_val, mean_unc, sigma_val, sigma_unc
    input  logic [135:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // group_key, avg_mean, avg_mean_err, avg_sigma, avg_sigma_err
    output logic [135:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CW = gwa_pkg::COUNT_W;

    gwa_pkg::seq_state_t state_reg, state_next;
    gwa_pkg::unit_cmd_t  cmd;
    gwa_pkg::unit_sts_t  sts;

    // latched request
    logic [7:0]  key_reg;
    logic [31:0] val_reg [2];
    logic [31:0] unc_reg [2];
    logic        final_reg;

    // group state
    logic [7:0]    open_key_reg;
    logic          group_open_reg;
    logic [CW-1:0] count_reg;
    logic [63:0]   wsum_reg    [2];
    logic [63:0]   weights_reg [2];
    logic [63:0]   sqsum_reg   [2];
    logic          sat_reg;
    logic          cflag_reg;
    logic [31:0]   solo_val_reg [2];
    logic [31:0]   solo_unc_reg [2];

    // sequencer work registers
    logic        ch_reg;
    logic        issued_reg;
    logic        ret_add_reg;
    logic        done_tag_reg;
    logic [31:0] r_reg;
    logic [63:0] prod_reg;
    logic [31:0] sroot_reg;
    logic [31:0] res_val_reg [2];
    logic [31:0] res_unc_reg [2];

    // output register
    logic         out_valid_reg;
    logic [135:0] out_data_reg;
    logic         out_sat_reg;
    logic         out_last_reg;

    logic        close_req;
    logic        out_free;
    logic [63:0] wsum_cur;
    logic [63:0] mag;
    logic        neg;
    logic [64:0] sadd;
    logic [64:0] wadd;
    logic [64:0] qadd;
    logic        s_ovf;
    logic [63:0] s_sat;
    logic [63:0] q;

    gwa_divsqrt u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    assign s_tready = (state_reg == gwa_pkg::S_IDLE);
    assign out_free = ~out_valid_reg | m_tready;
    assign close_req = group_open_reg &&
                       ((s_tdata[7:0] != open_key_reg) || (count_reg >= CW'(gwa_pkg::MAX_GROUP)));

    // saturating adds and the signed magnitude for the value division
    always_comb
    begin
        wsum_cur = wsum_reg[ch_reg];
        neg      = wsum_cur[63];
        mag      = neg ? (~wsum_cur + 64'd1) : wsum_cur;
        sadd     = {wsum_cur[63], wsum_cur} + {prod_reg[63], prod_reg};
        s_ovf    = sadd[64] != sadd[63];
        s_sat    = prod_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        wadd     = {1'b0, weights_reg[ch_reg]} + {33'd0, r_reg};
        qadd     = {1'b0, sqsum_reg[ch_reg]} + {1'b0, prod_reg};
        q        = sts.result;
    end

    // unit command per state
    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = gwa_pkg::OP_DIV;
        cmd.a     = gwa_pkg::RECIP_NUM;
        cmd.b     = {32'd0, unc_reg[ch_reg]};
        case (state_reg)
            gwa_pkg::S_RECIP:
            begin
                cmd.start = ~issued_reg && (unc_reg[ch_reg] != 32'd0);
            end
            gwa_pkg::S_WDIV:
            begin
                cmd.start = ~issued_reg && (count_reg > CW'(1)) &&
                            (weights_reg[ch_reg] != 64'd0);
                cmd.a     = mag;
                cmd.b     = weights_reg[ch_reg];
            end
            gwa_pkg::S_SQRT:
            begin
                cmd.start = ~issued_reg;
                cmd.op    = gwa_pkg::OP_SQRT;
                cmd.a     = sqsum_reg[ch_reg];
            end
            gwa_pkg::S_SQDIV:
            begin
                cmd.start = ~issued_reg;
                cmd.a     = {32'd0, sroot_reg};
                cmd.b     = 64'(count_reg);
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gwa_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = close_req ? gwa_pkg::S_WDIV : gwa_pkg::S_OPEN;
            end
            gwa_pkg::S_OPEN:  state_next = gwa_pkg::S_RECIP;
            gwa_pkg::S_RECIP:
            begin
                if (unc_reg[ch_reg] == 32'd0 || (issued_reg && sts.done))
                    state_next = gwa_pkg::S_MULW;
            end
            gwa_pkg::S_MULW:  state_next = gwa_pkg::S_ADDW;
            gwa_pkg::S_ADDW:  state_next = gwa_pkg::S_ADDSQ;
            gwa_pkg::S_ADDSQ:
            begin
                if (!ch_reg)
                    state_next = gwa_pkg::S_RECIP;
                else if (final_reg)
                    state_next = gwa_pkg::S_WDIV;
                else
                    state_next = gwa_pkg::S_IDLE;
            end
            gwa_pkg::S_WDIV:
            begin
                if (count_reg <= CW'(1))
                    state_next = gwa_pkg::S_EMIT;
                else if (weights_reg[ch_reg] == 64'd0 || (issued_reg && sts.done))
                    state_next = gwa_pkg::S_SQRT;
            end
            gwa_pkg::S_SQRT:
            begin
                if (issued_reg && sts.done)
                    state_next = gwa_pkg::S_SQDIV;
            end
            gwa_pkg::S_SQDIV:
            begin
                if (issued_reg && sts.done)
                    state_next = ch_reg ? gwa_pkg::S_EMIT : gwa_pkg::S_WDIV;
            end
            gwa_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = ret_add_reg ? gwa_pkg::S_OPEN : gwa_pkg::S_IDLE;
            end
            default: state_next = gwa_pkg::S_IDLE;
        endcase
    end

    // sequencer, group state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= gwa_pkg::S_IDLE;
            open_key_reg   <= '0;
            group_open_reg <= 1'b0;
            count_reg      <= '0;
            wsum_reg[0]    <= '0;
            wsum_reg[1]    <= '0;
            weights_reg[0] <= '0;
            weights_reg[1] <= '0;
            sqsum_reg[0]   <= '0;
            sqsum_reg[1]   <= '0;
            sat_reg        <= 1'b0;
            cflag_reg      <= 1'b0;
            ch_reg         <= 1'b0;
            issued_reg     <= 1'b0;
            ret_add_reg    <= 1'b0;
            done_tag_reg   <= 1'b0;
            final_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gwa_pkg::S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.start)
                issued_reg <= 1'b1;
            else if (sts.done)
                issued_reg <= 1'b0;

            case (state_reg)
                // take a request
                gwa_pkg::S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        key_reg      <= s_tdata[7:0];
                        val_reg[0]   <= s_tdata[39:8];
                        unc_reg[0]   <= s_tdata[71:40];
                        val_reg[1]   <= s_tdata[103:72];
                        unc_reg[1]   <= s_tdata[135:104];
                        final_reg    <= s_tlast;
                        ch_reg       <= 1'b0;
                        ret_add_reg  <= close_req;
                        done_tag_reg <= 1'b0;
                    end
                end
                // open a group if none is open
                gwa_pkg::S_OPEN:
                begin
                    if (!group_open_reg)
                    begin
                        group_open_reg  <= 1'b1;
                        open_key_reg    <= key_reg;
                        solo_val_reg[0] <= val_reg[0];
                        solo_unc_reg[0] <= unc_reg[0];
                        solo_val_reg[1] <= val_reg[1];
                        solo_unc_reg[1] <= unc_reg[1];
                    end
                    count_reg <= count_reg + CW'(1);
                    ch_reg    <= 1'b0;
                end
                // reciprocal of the uncertainty
                gwa_pkg::S_RECIP:
                begin
                    if (unc_reg[ch_reg] == 32'd0)
                    begin
                        r_reg   <= '1;
                        sat_reg <= 1'b1;
                    end
                    else if (issued_reg && sts.done)
                    begin
                        if (q[63:32] != 32'd0)
                        begin
                            r_reg   <= '1;
                            sat_reg <= 1'b1;
                        end
                        else
                            r_reg <= q[31:0];
                    end
                end
                // weighted term
                gwa_pkg::S_MULW:
                begin
                    prod_reg <= 64'($signed(val_reg[ch_reg]) * $signed({1'b0, r_reg}));
                end
                // weighted sum, then squared term
                gwa_pkg::S_ADDW:
                begin
                    if (s_ovf)
                    begin
                        wsum_reg[ch_reg] <= s_sat;
                        sat_reg          <= 1'b1;
                    end
                    else
                        wsum_reg[ch_reg] <= sadd[63:0];
                    prod_reg <= 64'(unc_reg[ch_reg]) * 64'(unc_reg[ch_reg]);
                end
                // weight and square sums
                gwa_pkg::S_ADDSQ:
                begin
                    weights_reg[ch_reg] <= wadd[64] ? '1 : wadd[63:0];
                    sqsum_reg[ch_reg]   <= qadd[64] ? '1 : qadd[63:0];
                    if (wadd[64] || qadd[64])
                        sat_reg <= 1'b1;
                    if (!ch_reg)
                        ch_reg <= 1'b1;
                    else if (final_reg)
                    begin
                        ch_reg       <= 1'b0;
                        ret_add_reg  <= 1'b0;
                        done_tag_reg <= 1'b1;
                    end
                end
                // combined value
                gwa_pkg::S_WDIV:
                begin
                    if (count_reg <= CW'(1))
                    begin
                        res_val_reg[0] <= solo_val_reg[0];
                        res_unc_reg[0] <= solo_unc_reg[0];
                        res_val_reg[1] <= solo_val_reg[1];
                        res_unc_reg[1] <= solo_unc_reg[1];
                    end
                    else if (weights_reg[ch_reg] == 64'd0)
                    begin
                        res_val_reg[ch_reg] <= '0;
                        cflag_reg           <= 1'b1;
                    end
                    else if (issued_reg && sts.done)
                    begin
                        if (neg)
                        begin
                            if (q > 64'h8000_0000)
                            begin
                                res_val_reg[ch_reg] <= 32'h8000_0000;
                                cflag_reg           <= 1'b1;
                            end
                            else
                                res_val_reg[ch_reg] <= 32'd0 - q[31:0];
                        end
                        else
                        begin
                            if (q > 64'h7FFF_FFFF)
                            begin
                                res_val_reg[ch_reg] <= 32'h7FFF_FFFF;
                                cflag_reg           <= 1'b1;
                            end
                            else
                                res_val_reg[ch_reg] <= q[31:0];
                        end
                    end
                end
                // root of the square sum
                gwa_pkg::S_SQRT:
                begin
                    if (issued_reg && sts.done)
                        sroot_reg <= q[31:0];
                end
                // root over count
                gwa_pkg::S_SQDIV:
                begin
                    if (issued_reg && sts.done)
                    begin
                        res_unc_reg[ch_reg] <= q[31:0];
                        ch_reg              <= 1'b1;
                    end
                end
                // hand out the result and clear the group
                gwa_pkg::S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_data_reg   <= {res_unc_reg[1], res_val_reg[1],
                                           res_unc_reg[0], res_val_reg[0], open_key_reg};
                        out_sat_reg    <= sat_reg | cflag_reg;
                        out_last_reg   <= done_tag_reg;
                        group_open_reg <= 1'b0;
                        count_reg      <= '0;
                        wsum_reg[0]    <= '0;
                        wsum_reg[1]    <= '0;
                        weights_reg[0] <= '0;
                        weights_reg[1] <= '0;
                        sqsum_reg[0]   <= '0;
                        sqsum_reg[1]   <= '0;
                        sat_reg        <= 1'b0;
                        cflag_reg      <= 1'b0;
                        ch_reg         <= 1'b0;
                    end
                end
                default:
                begin
                    ch_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

### design/gwa_checker.sv
// Port checker for grouped_weighted_average, bound to the top level.
// Watches only the stream ports. Depends on nothing else.
module gwa_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // one request at a time
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no result appears in the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind grouped_weighted_average gwa_checker u_gwa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
